FILE: sv/siq_pkg.sv
package siq_pkg;

   localparam int KEY_W       = 32;
   localparam int POS_W       = 7;
   localparam int ID_OUT_W    = 7;
   localparam int COUNT_OUT_W = 8;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // broadcast from the top level to every cell of the chain
   typedef struct packed {
      logic                    load;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        read_pos;
   } cell_ctrl_type;

endpackage

FILE: sv/sorted_insertion_queue.sv
// Sorted insertion queue: a chain of CAPACITY cells, each holding one list position
// (identifier and key), kept in ascending signed key order. An insert compares the key
// against every cell at once; cells with a smaller key hold, the first other cell takes
// the new entry and the rest shift one place along. The response is registered, and a
// new request is accepted whenever that register is empty or being emptied in the same
// cycle. Reads select the cell at the given position through an OR tree across the
// chain. A clear only resets the entry count.
module sorted_insertion_queue #(
   parameter int CAPACITY = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic signed [siq_pkg::KEY_W-1:0] req_key,
   input  logic [siq_pkg::POS_W-1:0]        req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [siq_pkg::ID_OUT_W-1:0]     rsp_entry_id,
   output logic                             rsp_rejected,
   output logic [siq_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);
   import siq_pkg::*;

   localparam int IW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

   logic                    accept;
   logic                    full;
   cell_ctrl_type           ctrl;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ID_OUT_W-1:0]     rsp_entry_id_ff, rsp_entry_id_in;
   logic                    rsp_rejected_ff, rsp_rejected_in;
   logic [COUNT_OUT_W-1:0]  rsp_entry_count_ff, rsp_entry_count_in;

   logic [CAPACITY-1:0]           less;
   logic [IW-1:0]                 ids  [CAPACITY];
   logic signed [KEY_W-1:0]       keys [CAPACITY];
   logic [IW-1:0]                 hits [CAPACITY];
   logic [IW-1:0]                 read_hit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CW'(CAPACITY);

   assign ctrl.load     = accept && req_op == OP_INSERT && !full;
   assign ctrl.key      = req_key;
   assign ctrl.read_pos = req_position;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         siq_cell #(.INDEX(i), .IW(IW)) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .occupied  (count_ff > CW'(i)),
            .new_id    (IW'(count_ff)),
            .prev_less (1'b1),
            .prev_id   ('0),
            .prev_key  ('0),
            .less      (less[i]),
            .id        (ids[i]),
            .key       (keys[i]),
            .hit_id    (hits[i])
         );
      end else begin : g_body
         siq_cell #(.INDEX(i), .IW(IW)) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .occupied  (count_ff > CW'(i)),
            .new_id    (IW'(count_ff)),
            .prev_less (less[i-1]),
            .prev_id   (ids[i-1]),
            .prev_key  (keys[i-1]),
            .less      (less[i]),
            .id        (ids[i]),
            .key       (keys[i]),
            .hit_id    (hits[i])
         );
      end
   end

   always_comb begin
      read_hit = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_hit = read_hit | hits[i];
      end
   end

   always_comb begin
      count_in           = count_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_entry_id_in    = rsp_entry_id_ff;
      rsp_rejected_in    = rsp_rejected_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in    = 1'b1;
         rsp_entry_id_in = '0;
         rsp_rejected_in = 1'b0;
         case (req_op)
            OP_INSERT: begin
               if (full) begin
                  rsp_rejected_in = 1'b1;
               end else begin
                  rsp_entry_id_in = ID_OUT_W'(count_ff);
                  count_in        = count_ff + CW'(1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            OP_READ: begin
               if (CMP_W'(req_position) < CMP_W'(count_ff)) begin
                  rsp_entry_id_in = ID_OUT_W'(read_hit);
               end else begin
                  rsp_rejected_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         rsp_entry_count_in = COUNT_OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_entry_id_ff    <= rsp_entry_id_in;
      rsp_rejected_ff    <= rsp_rejected_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_id    = rsp_entry_id_ff;
   assign rsp_rejected    = rsp_rejected_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

FILE: sv/siq_cell.sv
module siq_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 7
) (
   input  logic                          clock,
   input  siq_pkg::cell_ctrl_type        ctrl,
   input  logic                          occupied,
   input  logic [IW-1:0]                 new_id,
   input  logic                          prev_less,
   input  logic [IW-1:0]                 prev_id,
   input  logic signed [siq_pkg::KEY_W-1:0] prev_key,
   output logic                          less,
   output logic [IW-1:0]                 id,
   output logic signed [siq_pkg::KEY_W-1:0] key,
   output logic [IW-1:0]                 hit_id
);
   import siq_pkg::*;

   localparam bit ADDRESSABLE = INDEX < (1 << POS_W);

   logic [IW-1:0]           id_ff, id_in;
   logic signed [KEY_W-1:0] key_ff, key_in;

   assign less = occupied && (key_ff < ctrl.key);

   always_comb begin
      id_in  = id_ff;
      key_in = key_ff;
      if (ctrl.load && !less) begin
         if (prev_less) begin
            // first position not smaller: take the new entry here
            id_in  = new_id;
            key_in = ctrl.key;
         end else begin
            // advance the neighbour's entry one place
            id_in  = prev_id;
            key_in = prev_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      key_ff <= key_in;
   end

   assign id     = id_ff;
   assign key    = key_ff;
   assign hit_id = (ADDRESSABLE && ctrl.read_pos == POS_W'(INDEX)) ? id_ff : '0;

endmodule

FILE: tb/sorted_insertion_queue_tb.sv
`timescale 1ns / 1ps

module sorted_insertion_queue_tb;
   import siq_pkg::*;

   localparam int LIST_DEPTH  = 128;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 20;

   // op code 3 is not decoded by the block
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct packed {
      logic [ID_OUT_W-1:0]    entry_id;
      logic                   rejected;
      logic [COUNT_OUT_W-1:0] entry_count;
   } outcome_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [1:0]                       req_op;
   logic signed [KEY_W-1:0]          req_key;
   logic [POS_W-1:0]                 req_position;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [ID_OUT_W-1:0]              rsp_entry_id;
   logic                             rsp_rejected;
   logic [COUNT_OUT_W-1:0]           rsp_entry_count;

   // shadow copy of the sorted list
   logic [ID_OUT_W-1:0]              shadow_order [LIST_DEPTH];
   logic signed [KEY_W-1:0]          shadow_key   [LIST_DEPTH];
   int                               shadow_count;

   outcome_type                      awaited_outcomes [$];
   outcome_type                      head_outcome;
   int                               error_count;
   int                               cycle_count;
   int                               send_idle_pct;
   int                               recv_stall_pct;
   int                               rsp_hold_cycles;

   sorted_insertion_queue #(
      .CAPACITY(LIST_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_entry_id   (rsp_entry_id),
      .rsp_rejected   (rsp_rejected),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_insertion_queue_tb: errors");
         $finish;
      end
   end

   function automatic outcome_type apply_to_shadow_list(input logic [1:0] op,
                                                        input logic signed [KEY_W-1:0] key,
                                                        input logic [POS_W-1:0] pos);
      outcome_type res;
      int          slot;
      int          i;
      res = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= LIST_DEPTH) begin
               res.rejected = 1'b1;
            end else begin
               // place ahead of the first entry whose key is not smaller
               slot = 0;
               while (slot < shadow_count && shadow_key[shadow_order[slot]] < key)
                  slot++;
               for (i = shadow_count; i > slot; i--)
                  shadow_order[i] = shadow_order[i-1];
               shadow_order[slot]       = ID_OUT_W'(shadow_count);
               shadow_key[shadow_count] = key;
               res.entry_id             = ID_OUT_W'(shadow_count);
               shadow_count++;
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         OP_READ: begin
            if (pos < shadow_count)
               res.entry_id = shadow_order[pos];
            else
               res.rejected = 1'b1;
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_OUT_W'(shadow_count);
      return res;
   endfunction

   function automatic logic signed [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 5))
         0:       return KEY_MAX;
         1:       return KEY_MIN;
         2, 3:    return $urandom_range(0, 8) - 4;
         default: return $urandom();
      endcase
   endfunction

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_request(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                               input logic [POS_W-1:0] pos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_key      <= key;
      req_position <= pos;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      awaited_outcomes.push_back(apply_to_shadow_list(op, key, pos));
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: response with nothing outstanding: id %0d rejected %0d count %0d",
                     $time, rsp_entry_id, rsp_rejected, rsp_entry_count);
            error_count++;
         end else begin
            head_outcome = awaited_outcomes.pop_front();
            if (rsp_entry_id !== head_outcome.entry_id) begin
               $display("%0t: entry_id expected %0d actual %0d",
                        $time, head_outcome.entry_id, rsp_entry_id);
               error_count++;
            end
            if (rsp_rejected !== head_outcome.rejected) begin
               $display("%0t: rejected expected %0d actual %0d",
                        $time, head_outcome.rejected, rsp_rejected);
               error_count++;
            end
            if (rsp_entry_count !== head_outcome.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, head_outcome.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      int p;
      send_request(OP_READ, 0, 0);
      send_request(OP_READ, 0, 7'd127);
      send_request(OP_SPARE, KEY_MAX, 7'd127);
      send_request(OP_INSERT, 0, 0);
      send_request(OP_INSERT, KEY_MAX, 0);
      send_request(OP_INSERT, KEY_MIN, 0);
      send_request(OP_INSERT, -1, 0);
      // equal keys: newest goes first
      send_request(OP_INSERT, 0, 0);
      send_request(OP_INSERT, KEY_MAX, 0);
      send_request(OP_INSERT, KEY_MIN, 0);
      for (p = 0; p < 7; p++)
         send_request(OP_READ, 0, POS_W'(p));
      send_request(OP_READ, 0, 7'd7);
      send_request(OP_SPARE, 0, 0);
      send_request(OP_CLEAR, 0, 0);
      send_request(OP_READ, 0, 0);
      // identifiers restart from zero after a clear
      send_request(OP_INSERT, 32'sh5555_5555, 7'h55);
      send_request(OP_INSERT, 32'shAAAA_AAAA, 7'h2A);
      send_request(OP_READ, 0, 0);
      send_request(OP_READ, 0, 1);
   endtask

   task automatic test_capacity_fill();
      int n;
      send_request(OP_CLEAR, 0, 0);
      for (n = 0; n < LIST_DEPTH; n++)
         send_request(OP_INSERT, rand_key(), POS_W'($urandom()));
      send_request(OP_INSERT, rand_key(), 0);
      send_request(OP_INSERT, KEY_MIN, 0);
      for (n = 0; n < LIST_DEPTH; n++)
         send_request(OP_READ, rand_key(), POS_W'(n));
      send_request(OP_SPARE, 0, 0);
      send_request(OP_CLEAR, 0, 0);
   endtask

   task automatic test_random_traffic(input int items, input int idle_pct,
                                      input int stall_pct);
      int                  n;
      int                  pick;
      logic [POS_W-1:0]    pos;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (shadow_count > 0 && $urandom_range(0, 9) < 7)
            pos = POS_W'($urandom_range(0, shadow_count - 1));
         else
            pos = POS_W'($urandom());
         if (pick < 50)
            send_request(OP_INSERT, rand_key(), pos);
         else if (pick < 90)
            send_request(OP_READ, rand_key(), pos);
         else if (pick < 94)
            send_request(OP_CLEAR, rand_key(), pos);
         else
            send_request(OP_SPARE, rand_key(), pos);
      end
   endtask

   task automatic test_receiver_hold();
      int n;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 300;
      for (n = 0; n < 30; n++)
         send_request(n % 3 == 0 ? OP_READ : OP_INSERT, rand_key(), POS_W'(n));
   endtask

   task automatic test_sender_pause();
      int n;
      send_idle_pct  = 24;
      recv_stall_pct = 24;
      for (n = 0; n < 10; n++)
         send_request(OP_INSERT, rand_key(), 0);
      wait_for_drain();
      for (n = 0; n < 10; n++)
         send_request(OP_READ, 0, POS_W'($urandom_range(0, 15)));
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_INSERT;
      req_key         = '0;
      req_position    = '0;
      rsp_ready       = 1'b0;
      shadow_count    = 0;
      error_count     = 0;
      cycle_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_capacity_fill();
      test_random_traffic(150, 0, 0);
      test_random_traffic(150, 69, 0);
      test_random_traffic(150, 0, 69);
      test_random_traffic(150, 24, 24);
      test_receiver_hold();
      test_sender_pause();

      wait_for_drain();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_insertion_queue_tb: clean");
      end else begin
         $display("sorted_insertion_queue_tb: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/siq_pkg.sv
sv/siq_cell.sv
sv/sorted_insertion_queue.sv
tb/sorted_insertion_queue_tb.sv
